// ===== src/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants of the sorted list engine
// Operation and status codes, the controller states, the cell command and chain status.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int OP_W         = 3;
  localparam int STATUS_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_SEARCH = 3'd2,
    OP_PRINT  = 3'd3,
    OP_LAST   = 3'd4,
    OP_NTH    = 3'd5,
    OP_CLEAR  = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PRINT
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctl_t;

  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] picked;
    logic [DATA_W-1:0] head;
  } chain_stat_t;

endpackage

// ===== src/sle_cell.sv =====
// ----------------------------------------------------------------------------
// sle_cell: one slot of the sorted chain
// Holds one value, compares it against the operand and shifts with neighbours.
// ----------------------------------------------------------------------------
module sle_cell
  import sle_pkg::*;
(
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] arg,
  input  logic                     valid,
  input  logic                     tail,
  input  logic                     sel,
  input  logic                     lt_left,
  input  logic        [DATA_W-1:0] val_left,
  input  logic        [DATA_W-1:0] val_right,
  input  logic        [DATA_W-1:0] val_head,
  output logic        [DATA_W-1:0] val,
  output logic                     lt,
  output logic                     eq,
  output logic                     pick
);

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_CMP: begin
        lt   <= valid && ($signed(val) < arg);
        eq   <= valid && (val == arg);
        pick <= sel;
      end
      CELL_INS: begin
        // stay put if smaller, else take the new value or the left neighbour
        if (!lt) begin
          val <= lt_left ? arg : val_left;
        end
      end
      CELL_DEL: begin
        if (!lt) begin
          val <= val_right;
        end
      end
      CELL_ROT: begin
        val <= tail ? val_head : val_right;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/sle_chain.sv =====
// ----------------------------------------------------------------------------
// sle_chain: row of cells with neighbour wiring
// Derives per-cell valid, tail and select flags and gathers match results.
// ----------------------------------------------------------------------------
module sle_chain
  import sle_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int CNTW = $clog2(CAPACITY + 1),
  localparam int IDXW = $clog2(CAPACITY)
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] arg,
  input  logic        [CNTW-1:0]   count,
  input  logic        [IDXW-1:0]   sel_idx,
  output chain_stat_t              stat
);

  logic [DATA_W-1:0] vals [CAPACITY];
  logic [CAPACITY-1:0] lts;
  logic [CAPACITY-1:0] eqs;
  logic [CAPACITY-1:0] picks;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNTW-1:0] POS     = CNTW'(i);
    localparam logic [CNTW-1:0] POS_P1  = CNTW'(i + 1);
    localparam logic [IDXW-1:0] IDX     = IDXW'(i);

    logic              lt_left;
    logic [DATA_W-1:0] val_left;
    logic [DATA_W-1:0] val_right;

    if (i == 0) begin : g_first
      assign lt_left  = 1'b1;
      assign val_left = vals[0];
    end else begin : g_mid
      assign lt_left  = lts[i-1];
      assign val_left = vals[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign val_right = vals[i];
    end else begin : g_inner
      assign val_right = vals[i+1];
    end

    sle_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .arg       (arg),
      .valid     (POS < count),
      .tail      (POS_P1 == count),
      .sel       (IDX == sel_idx),
      .lt_left   (lt_left),
      .val_left  (val_left),
      .val_right (val_right),
      .val_head  (vals[0]),
      .val       (vals[i]),
      .lt        (lts[i]),
      .eq        (eqs[i]),
      .pick      (picks[i])
    );
  end

  // one-hot and-or gather of the picked cell
  always_comb begin
    stat.found  = |eqs;
    stat.head   = vals[0];
    stat.picked = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      stat.picked = stat.picked | (vals[k] & {DATA_W{picks[k]}});
    end
  end

endmodule

// ===== src/sorted_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// sorted_list_engine_core: sorted list of signed values in a chain of cells
// Insert, delete, search, print, last, nth and clear on up to CAPACITY values.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Every item except
// print passes through the compare and execute steps only: the accepting edge
// makes every cell compare its value against the operand in parallel, and the
// next edge acts on those registered flags (shift for insert or delete, gather
// for search, last and nth). The result appears on the cycle after that, one
// cycle wide under result_strobe, and cannot be held off by the receiver,
// so it must be taken when shown. Print on a filled list then passes over its
// values: the chain rotates by one cell each cycle and the head cell is sent
// out, so after a full pass the list is back in place; last_of_run marks the
// final value. A new item may be accepted in the cycle its last result is
// shown. Operation code 7 is swallowed with no result.
// ----------------------------------------------------------------------------
module sorted_list_engine_core
  import sle_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int CNTW = $clog2(CAPACITY + 1),
  localparam int IDXW = $clog2(CAPACITY)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic        [OP_W-1:0]     operation,
  input  logic signed [DATA_W-1:0]   operand,
  output logic                       result_strobe,
  output logic        [STATUS_W-1:0] status,
  output logic signed [DATA_W-1:0]   value,
  output logic                       last_of_run
);

  localparam logic [CNTW-1:0] FULL_COUNT = CNTW'(CAPACITY);
  localparam logic [CNTW-1:0] ONE        = CNTW'(1);

  // control registers
  state_t          state, state_next;
  logic [CNTW-1:0] count, count_next;
  logic [CNTW-1:0] prn_cnt, prn_cnt_next;
  logic            result_strobe_next;

  // item registers, no reset needed
  logic [OP_W-1:0]          op_q;
  logic signed [DATA_W-1:0] arg_q;
  logic                     beyond;
  logic [STATUS_W-1:0]      status_next;
  logic [DATA_W-1:0]        value_next;
  logic                     last_next;

  logic        accept;
  cell_ctl_t   cell_ctl;
  chain_stat_t chain_stat;
  logic signed [DATA_W-1:0] cell_arg;
  logic [IDXW-1:0]          sel_idx;
  logic                     nonpos;
  logic [DATA_W-1:0]        pos_m1;
  logic                     empty;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign empty  = (count == '0);

  // cells compare against the live operand on the accepting edge
  assign cell_arg = busy ? arg_q : operand;

  // nth position: zero and below read the first cell
  assign nonpos = operand[DATA_W-1] || (operand == '0);
  assign pos_m1 = operand - DATA_W'(1);

  always_comb begin
    if (op_t'(operation) == OP_LAST) begin
      sel_idx = IDXW'(count - ONE);
    end else if (nonpos) begin
      sel_idx = '0;
    end else begin
      sel_idx = pos_m1[IDXW-1:0];
    end
  end

  sle_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk     (clk),
    .ctl     (cell_ctl),
    .arg     (cell_arg),
    .count   (count),
    .sel_idx (sel_idx),
    .stat    (chain_stat)
  );

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      prn_cnt       <= '0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      count         <= count_next;
      prn_cnt       <= prn_cnt_next;
      result_strobe <= result_strobe_next;
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= operation;
      arg_q  <= operand;
      beyond <= !nonpos && (operand > DATA_W'(count));
    end
    status      <= status_next;
    value       <= value_next;
    last_of_run <= last_next;
  end

  // next state, cell commands and result
  always_comb begin
    state_next         = state;
    count_next         = count;
    prn_cnt_next       = prn_cnt;
    cell_ctl.op        = CELL_HOLD;
    result_strobe_next = 1'b0;
    status_next        = ST_OK;
    value_next         = '0;
    last_next          = 1'b1;

    case (state)
      S_IDLE: begin
        if (start) begin
          cell_ctl.op = CELL_CMP;
          state_next  = S_EXEC;
        end
      end

      S_EXEC: begin
        state_next         = S_IDLE;
        result_strobe_next = 1'b1;
        case (op_q)
          OP_INSERT: begin
            if (count == FULL_COUNT) begin
              status_next = ST_FULL;
            end else begin
              cell_ctl.op = CELL_INS;
              count_next  = count + ONE;
            end
          end
          OP_DELETE: begin
            if (empty) begin
              status_next = ST_EMPTY;
            end else if (chain_stat.found) begin
              cell_ctl.op = CELL_DEL;
              count_next  = count - ONE;
            end else begin
              status_next = ST_NOT_FOUND;
            end
          end
          OP_SEARCH: begin
            if (empty) begin
              status_next = ST_EMPTY;
            end else if (chain_stat.found) begin
              value_next = arg_q;
            end else begin
              status_next = ST_NOT_FOUND;
            end
          end
          OP_PRINT: begin
            if (empty) begin
              status_next = ST_EMPTY;
            end else begin
              // the pass itself emits the results
              result_strobe_next = 1'b0;
              prn_cnt_next       = '0;
              state_next         = S_PRINT;
            end
          end
          OP_LAST: begin
            if (empty) begin
              status_next = ST_EMPTY;
            end else begin
              value_next = chain_stat.picked;
            end
          end
          OP_NTH: begin
            if (empty) begin
              status_next = ST_EMPTY;
            end else if (beyond) begin
              status_next = ST_NOT_FOUND;
            end else begin
              value_next = chain_stat.picked;
            end
          end
          OP_CLEAR: begin
            count_next = '0;
          end
          default: begin
            // unused code: nothing to report
            result_strobe_next = 1'b0;
          end
        endcase
      end

      S_PRINT: begin
        cell_ctl.op        = CELL_ROT;
        result_strobe_next = 1'b1;
        value_next         = chain_stat.head;
        prn_cnt_next       = prn_cnt + ONE;
        last_next          = (prn_cnt + ONE == count);
        if (prn_cnt + ONE == count) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // the fill level never passes the capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count above capacity");

  // an accepted item always occupies the block on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EXEC))
    else $error("accepted item not executed");

  // results only follow execution or the print pass
  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> ($past(state) == S_EXEC || $past(state) == S_PRINT))
    else $error("result without work");

  // insert into a full list is refused and keeps the count
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && op_q == OP_INSERT && count == FULL_COUNT)
      |=> (result_strobe && status == ST_FULL && count == FULL_COUNT))
    else $error("full insert not refused");

  // a print pass ends with the last flag set
  a_print_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_PRINT && state_next == S_IDLE) |=> (result_strobe && last_of_run))
    else $error("print pass without final flag");
`endif

endmodule

// ===== tb/sle_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sle_checker: result checker for the sorted list engine
// Mirrors the list on every accepted item and compares each strobed result
// in order, field by field, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sle_checker
  import sle_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic        [OP_W-1:0]     operation,
  input  logic signed [DATA_W-1:0]   operand,
  input  logic                       result_strobe,
  input  logic        [STATUS_W-1:0] status,
  input  logic signed [DATA_W-1:0]   value,
  input  logic                       last_of_run,
  output int                         mismatch_count,
  output int                         results_outstanding
);

  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] value;
    logic                     last_flag;
  } list_result_t;

  logic signed [DATA_W-1:0] shadow_list [CAPACITY_DEF];
  int                       shadow_count;
  list_result_t             awaited_results [$];
  int                       fail_tally = 0;

  initial begin
    mismatch_count      = 0;
    results_outstanding = 0;
    shadow_count        = 0;
  end

  task automatic push_result(input status_t st, input logic signed [DATA_W-1:0] v,
                             input logic lf);
    list_result_t r;
    r.status    = st;
    r.value     = v;
    r.last_flag = lf;
    awaited_results.push_back(r);
  endtask

  // update the mirrored list and queue the results one item causes
  task automatic apply_list_op(input logic [OP_W-1:0] code,
                               input logic signed [DATA_W-1:0] arg);
    int pos;
    int k;
    pos = 0;
    case (code)
      OP_INSERT: begin
        if (shadow_count >= CAPACITY_DEF) begin
          push_result(ST_FULL, '0, 1'b1);
        end else begin
          while (pos < shadow_count && shadow_list[pos] < arg) pos++;
          for (k = shadow_count; k > pos; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[pos] = arg;
          shadow_count++;
          push_result(ST_OK, '0, 1'b1);
        end
      end
      OP_DELETE, OP_SEARCH: begin
        if (shadow_count == 0) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          while (pos < shadow_count && shadow_list[pos] != arg) pos++;
          if (pos == shadow_count) begin
            push_result(ST_NOT_FOUND, '0, 1'b1);
          end else if (code == OP_SEARCH) begin
            push_result(ST_OK, arg, 1'b1);
          end else begin
            for (k = pos; k < shadow_count - 1; k++) shadow_list[k] = shadow_list[k+1];
            shadow_count--;
            push_result(ST_OK, '0, 1'b1);
          end
        end
      end
      OP_PRINT: begin
        if (shadow_count == 0) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (k = 0; k < shadow_count; k++)
            push_result(ST_OK, shadow_list[k], k == shadow_count - 1);
        end
      end
      OP_LAST: begin
        if (shadow_count == 0) push_result(ST_EMPTY, '0, 1'b1);
        else push_result(ST_OK, shadow_list[shadow_count-1], 1'b1);
      end
      OP_NTH: begin
        // positions of zero and below read the head
        if (shadow_count == 0) push_result(ST_EMPTY, '0, 1'b1);
        else if (arg <= 0) push_result(ST_OK, shadow_list[0], 1'b1);
        else if (arg > shadow_count) push_result(ST_NOT_FOUND, '0, 1'b1);
        else push_result(ST_OK, shadow_list[arg-1], 1'b1);
      end
      OP_CLEAR: begin
        shadow_count = 0;
        push_result(ST_OK, '0, 1'b1);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      shadow_count = 0;
      awaited_results.delete();
      fail_tally = 0;
    end else begin
      // results first: a new item may be taken on the edge its predecessor ends
      if (result_strobe) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: status %0d value %0d last_of_run %0b",
                 status, value, last_of_run);
          fail_tally++;
        end else begin
          want = awaited_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_tally++;
          end
          if (value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, value);
            fail_tally++;
          end
          if (last_of_run !== want.last_flag) begin
            $error("last_of_run: expected %0b, got %0b", want.last_flag, last_of_run);
            fail_tally++;
          end
        end
      end
      if (start && !busy) apply_list_op(operation, operand);
    end
    mismatch_count      <= fail_tally;
    results_outstanding <= awaited_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the sorted list engine core
// Directed corner items, then random traffic in fill, drain and mixed phases
// with bursty gaps; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top
  import sle_pkg::*;
();

  // code 7 is not an operation: the block must swallow it silently
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 420;
  // no gaps at all over the final stretch of items
  localparam int CALM_TAIL    = 60;
  localparam int POOL_N       = 12;

  // bias of the random traffic, chosen afresh for every phase after the first
  typedef enum {MIX_BALANCED, MIX_FILL, MIX_DRAIN} traffic_mix_t;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic        [OP_W-1:0]     operation;
  logic signed [DATA_W-1:0]   operand;
  logic                       result_strobe;
  logic        [STATUS_W-1:0] status;
  logic signed [DATA_W-1:0]   value;
  logic                       last_of_run;
  int                         mismatch_count;
  int                         results_outstanding;

  // small set of recurring values so that duplicates, hits and deletes happen
  logic signed [DATA_W-1:0]   value_pool [POOL_N];

  sorted_list_engine_core dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .operand       (operand),
    .result_strobe (result_strobe),
    .status        (status),
    .value         (value),
    .last_of_run   (last_of_run)
  );

  sle_checker list_checker (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .operation           (operation),
    .operand             (operand),
    .result_strobe       (result_strobe),
    .status              (status),
    .value               (value),
    .last_of_run         (last_of_run),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // mostly pool values, otherwise any 32-bit pattern
  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 3) return $urandom;
    return value_pool[$urandom_range(0, POOL_N-1)];
  endfunction

  // mostly in-range positions, some negative and some huge ones
  function automatic logic signed [DATA_W-1:0] pick_position();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, CAPACITY_DEF + 2);
    if (roll < 85) return $urandom | 32'h8000_0000;
    return $urandom;
  endfunction

  function automatic logic [OP_W-1:0] pick_operation(input traffic_mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (roll < 75) return OP_INSERT;
        if (roll < 82) return OP_SEARCH;
        if (roll < 88) return OP_NTH;
        if (roll < 92) return OP_PRINT;
        if (roll < 95) return OP_LAST;
        if (roll < 98) return OP_DELETE;
        return OP_UNUSED;
      end
      MIX_DRAIN: begin
        if (roll < 50) return OP_DELETE;
        if (roll < 65) return OP_SEARCH;
        if (roll < 75) return OP_INSERT;
        if (roll < 83) return OP_NTH;
        if (roll < 89) return OP_PRINT;
        if (roll < 94) return OP_LAST;
        if (roll < 97) return OP_CLEAR;
        return OP_UNUSED;
      end
      default: begin
        if (roll < 32) return OP_INSERT;
        if (roll < 50) return OP_DELETE;
        if (roll < 64) return OP_SEARCH;
        if (roll < 72) return OP_PRINT;
        if (roll < 79) return OP_LAST;
        if (roll < 91) return OP_NTH;
        if (roll < 95) return OP_CLEAR;
        return OP_UNUSED;
      end
    endcase
  endfunction

  // present one item and hold it until the block takes it;
  // start is left high so back-to-back items need no extra edge
  task automatic send_item(input logic [OP_W-1:0] code,
                           input logic signed [DATA_W-1:0] arg);
    start     <= 1'b1;
    operation <= code;
    operand   <= arg;
    do @(posedge clk); while (busy);
  endtask

  // sender gap, with junk on the payload that the block must ignore
  task automatic idle_for(input int cycles);
    start     <= 1'b0;
    operation <= OP_W'($urandom_range(0, 7));
    operand   <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  // hold off until every predicted result has been seen
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (results_outstanding != 0);
  endtask

  initial begin
    traffic_mix_t      mix;
    int                sent;
    int                phase_len;
    int                k;
    bit                calm;
    bit                mid_pause_done;
    logic [OP_W-1:0]   code;

    rst       <= 1'b1;
    start     <= 1'b0;
    operation <= OP_INSERT;
    operand   <= '0;
    value_pool[0] = 32'sh7FFF_FFFF;
    value_pool[1] = 32'sh8000_0000;
    value_pool[2] = 0;
    value_pool[3] = -1;
    value_pool[4] = 1;
    for (k = 5; k < POOL_N; k++) value_pool[k] = $urandom;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every operation but insert on the empty list, plus the unused code
    send_item(OP_DELETE, 5);
    send_item(OP_SEARCH, 5);
    send_item(OP_PRINT, 0);
    send_item(OP_LAST, 0);
    send_item(OP_NTH, 1);
    send_item(OP_CLEAR, 0);
    send_item(OP_UNUSED, 0);
    // extremes, sign boundary and a duplicate
    send_item(OP_INSERT, 32'sh7FFF_FFFF);
    send_item(OP_INSERT, 32'sh8000_0000);
    send_item(OP_INSERT, 0);
    send_item(OP_INSERT, -1);
    send_item(OP_INSERT, 0);
    send_item(OP_SEARCH, 0);
    send_item(OP_SEARCH, 5);
    // position zero, most negative position, last one and one beyond the count
    send_item(OP_NTH, 0);
    send_item(OP_NTH, 32'sh8000_0000);
    send_item(OP_NTH, 5);
    send_item(OP_NTH, 6);
    send_item(OP_LAST, 0);
    send_item(OP_PRINT, 0);
    send_item(OP_DELETE, 0);
    send_item(OP_DELETE, 5);
    send_item(OP_DELETE, 32'sh7FFF_FFFF);
    send_item(OP_CLEAR, 0);
    send_item(OP_PRINT, 0);
    wait_drained();

    // random phases; the first one fills the list so that full is reached early
    mix            = MIX_FILL;
    sent           = 0;
    mid_pause_done = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(20, 40);
      calm      = ($urandom_range(0, 3) == 0);
      value_pool[$urandom_range(5, POOL_N-1)] = $urandom;
      for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        if (!calm && sent < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
          idle_for($urandom_range(1, 11));
        code = pick_operation(mix);
        send_item(code, (code == OP_NTH) ? pick_position() : pick_value());
        if (code != OP_UNUSED) sent++;
      end
      // one full hold-off around the middle of the run
      if (!mid_pause_done && sent >= RANDOM_ITEMS / 2) begin
        wait_drained();
        mid_pause_done = 1'b1;
      end
      mix = traffic_mix_t'($urandom_range(0, 2));
    end

    // let the tail drain, then allow for a stray late strobe
    wait_drained();
    repeat (2 * CAPACITY_DEF + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
